### design/ptd_pkg.sv
package ptd_pkg;

	// Field and datapath widths, all derived from the 24-bit coordinate.
	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int DOT_W   = PROD_W + 2;
	localparam int HALF_W  = DOT_W / 2;
	localparam int CROSS_W = 2 * DOT_W;
	localparam int V_W     = CROSS_W + 2;
	localparam int DEN_W   = V_W + 2;
	localparam int TD_W    = DOT_W + 2;

	// Wide-by-narrow products are cut into chunks of the wide operand.
	localparam int CHUNK_W = 27;
	localparam int CK_W    = CHUNK_W + 1;
	localparam int NCHUNK  = (V_W + CHUNK_W - 1) / CHUNK_W;
	localparam int PART_W  = CK_W + DIFF_W;
	localparam int NUM_W   = V_W + DIFF_W + 1;

	// Divider: remainder, quotient and trial widths.
	localparam int REM_W   = NUM_W + 1;
	localparam int QUOT_W  = 27;
	localparam int CMP_W   = DEN_W + QUOT_W;
	localparam int OFS_W   = QUOT_W + 1;

	// Final distance arithmetic.
	localparam int DD_W    = COORD_W + 6;
	localparam int SQ_W    = 2 * DD_W;
	localparam int OUT_W   = 52;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		coord_t vert_a_x;
		coord_t vert_a_y;
		coord_t vert_a_z;
		coord_t vert_b_x;
		coord_t vert_b_y;
		coord_t vert_b_z;
		coord_t vert_c_x;
		coord_t vert_c_y;
		coord_t vert_c_z;
	} query_t;

	typedef struct packed {
		logic [OUT_W-1:0] distance_sq;
		logic             degenerate;
	} result_t;

	// Fields that ride along the arithmetic pipeline unchanged.
	typedef struct {
		logic [DEN_W-1:0] den;
		coord_t           base [3];
		coord_t           pt   [3];
		logic             deg;
	} side_t;

	// Numerator factors: sa * ea[i] + sb * eb[i], divided by side.den.
	typedef struct {
		logic signed [V_W-1:0]    sa;
		logic signed [V_W-1:0]    sb;
		logic signed [DIFF_W-1:0] ea [3];
		logic signed [DIFF_W-1:0] eb [3];
		side_t                    side;
	} job_t;

	// Per-axis restoring division state.
	typedef struct {
		logic [REM_W-1:0]  rem [3];
		logic              neg [3];
		logic [QUOT_W-1:0] quo [3];
		side_t             side;
	} div_t;

endpackage

### design/ptd_query_if.sv
interface ptd_query_if;
	import ptd_pkg::*;

	logic   valid;
	logic   ready;
	query_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/ptd_result_if.sv
interface ptd_result_if;
	import ptd_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/ptd_geom.sv
module ptd_geom (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ptd_pkg::query_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ptd_pkg::job_t   out_job
);
	import ptd_pkg::*;

	localparam int NSTG = 7;
	// Operand pairs of the six dot products (edge vector, point vector).
	localparam int DL [6] = '{0, 1, 0, 1, 0, 1};
	localparam int DR [6] = '{2, 2, 3, 3, 4, 4};
	// Operand pairs of the six cross terms d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
	localparam int XA [6] = '{0, 2, 4, 0, 2, 4};
	localparam int XB [6] = '{3, 1, 1, 5, 5, 3};

	logic vld_s [1:NSTG];
	logic rdy   [1:NSTG];

	coord_t                         pin    [4][3];
	coord_t                         pt_s1  [4][3];
	coord_t                         pt_s2  [4][3];
	coord_t                         pt_s3  [4][3];
	coord_t                         pt_s4  [4][3];
	coord_t                         pt_s5  [4][3];
	coord_t                         pt_s6  [4][3];
	logic signed [DIFF_W-1:0]       df_s1  [5][3];
	logic signed [PROD_W-1:0]       dp_s2  [6][3];
	logic signed [DOT_W-1:0]        d_s3   [6];
	logic signed [DOT_W-1:0]        d_s4   [6];
	logic signed [DOT_W-1:0]        d_s5   [6];
	logic signed [DOT_W-1:0]        d_s6   [6];
	logic signed [2*HALF_W-1:0]     hh_s4  [6];
	logic signed [2*HALF_W:0]       hl_s4  [6];
	logic signed [2*HALF_W:0]       lh_s4  [6];
	logic        [2*HALF_W-1:0]     ll_s4  [6];
	logic signed [CROSS_W-1:0]      x_s5   [6];
	logic signed [V_W-1:0]          va_s6;
	logic signed [V_W-1:0]          vb_s6;
	logic signed [V_W-1:0]          vc_s6;
	job_t                           job_s7;

	job_t                     job;
	logic signed [DEN_W-1:0]  den;
	logic signed [TD_W-1:0]   td_ab;
	logic signed [TD_W-1:0]   td_ac;
	logic signed [TD_W-1:0]   tn_bc;
	logic signed [TD_W-1:0]   td_bc;
	logic signed [DIFF_W-1:0] ab [3];
	logic signed [DIFF_W-1:0] ac [3];
	logic signed [DIFF_W-1:0] bc [3];
	logic                     f_a, f_b, f_ab, f_c, f_ac, f_bc;

	// A stage takes new data when it is empty or its successor moves.
	always_comb begin
		rdy[NSTG] = !vld_s[NSTG] || out_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_s[NSTG];
	assign out_job   = job_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Unpack the query into point P and vertices A, B, C.
	always_comb begin
		pin[0][0] = in_data.point_x;
		pin[0][1] = in_data.point_y;
		pin[0][2] = in_data.point_z;
		pin[1][0] = in_data.vert_a_x;
		pin[1][1] = in_data.vert_a_y;
		pin[1][2] = in_data.vert_a_z;
		pin[2][0] = in_data.vert_b_x;
		pin[2][1] = in_data.vert_b_y;
		pin[2][2] = in_data.vert_b_z;
		pin[3][0] = in_data.vert_c_x;
		pin[3][1] = in_data.vert_c_y;
		pin[3][2] = in_data.vert_c_z;
	end

	// Stage 1: edge and point difference vectors ab, ac, ap, bp, cp.
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			pt_s1 <= pin;
			for (int i = 0; i < 3; i++) begin
				df_s1[0][i] <= DIFF_W'(pin[2][i]) - DIFF_W'(pin[1][i]);
				df_s1[1][i] <= DIFF_W'(pin[3][i]) - DIFF_W'(pin[1][i]);
				df_s1[2][i] <= DIFF_W'(pin[0][i]) - DIFF_W'(pin[1][i]);
				df_s1[3][i] <= DIFF_W'(pin[0][i]) - DIFF_W'(pin[2][i]);
				df_s1[4][i] <= DIFF_W'(pin[0][i]) - DIFF_W'(pin[3][i]);
			end
		end
	end

	// Stage 2: per-axis products of the six dot products.
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			pt_s2 <= pt_s1;
			for (int j = 0; j < 6; j++) begin
				for (int i = 0; i < 3; i++) begin
					dp_s2[j][i] <= df_s1[DL[j]][i] * df_s1[DR[j]][i];
				end
			end
		end
	end

	// Stage 3: dot products d1 to d6.
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			pt_s3 <= pt_s2;
			for (int j = 0; j < 6; j++) begin
				d_s3[j] <= DOT_W'(dp_s2[j][0]) + DOT_W'(dp_s2[j][1]) + DOT_W'(dp_s2[j][2]);
			end
		end
	end

	// Stage 4: half-word partial products of the cross terms.
	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			pt_s4 <= pt_s3;
			d_s4  <= d_s3;
			for (int x = 0; x < 6; x++) begin
				hh_s4[x] <= $signed(d_s3[XA[x]][DOT_W-1:HALF_W])
					* $signed(d_s3[XB[x]][DOT_W-1:HALF_W]);
				hl_s4[x] <= $signed(d_s3[XA[x]][DOT_W-1:HALF_W])
					* $signed({1'b0, d_s3[XB[x]][HALF_W-1:0]});
				lh_s4[x] <= $signed({1'b0, d_s3[XA[x]][HALF_W-1:0]})
					* $signed(d_s3[XB[x]][DOT_W-1:HALF_W]);
				ll_s4[x] <= d_s3[XA[x]][HALF_W-1:0] * d_s3[XB[x]][HALF_W-1:0];
			end
		end
	end

	// Stage 5: recombine the partial products into full cross terms.
	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			pt_s5 <= pt_s4;
			d_s5  <= d_s4;
			for (int x = 0; x < 6; x++) begin
				x_s5[x] <= (CROSS_W'(hh_s4[x]) <<< (2 * HALF_W))
					+ ((CROSS_W'(hl_s4[x]) + CROSS_W'(lh_s4[x])) <<< HALF_W)
					+ $signed(CROSS_W'(ll_s4[x]));
			end
		end
	end

	// Stage 6: barycentric terms va, vb, vc.
	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			pt_s6 <= pt_s5;
			d_s6  <= d_s5;
			vc_s6 <= V_W'(x_s5[0]) - V_W'(x_s5[1]);
			vb_s6 <= V_W'(x_s5[2]) - V_W'(x_s5[3]);
			va_s6 <= V_W'(x_s5[4]) - V_W'(x_s5[5]);
		end
	end

	// Stage 7: region classification and choice of the division operands.
	always_comb begin
		den = DEN_W'(va_s6) + DEN_W'(vb_s6) + DEN_W'(vc_s6);
		for (int i = 0; i < 3; i++) begin
			ab[i] = DIFF_W'(pt_s6[2][i]) - DIFF_W'(pt_s6[1][i]);
			ac[i] = DIFF_W'(pt_s6[3][i]) - DIFF_W'(pt_s6[1][i]);
			bc[i] = DIFF_W'(pt_s6[3][i]) - DIFF_W'(pt_s6[2][i]);
		end
		td_ab = TD_W'(d_s6[0]) - TD_W'(d_s6[2]);
		td_ac = TD_W'(d_s6[1]) - TD_W'(d_s6[5]);
		tn_bc = TD_W'(d_s6[3]) - TD_W'(d_s6[2]);
		td_bc = tn_bc + TD_W'(d_s6[4]) - TD_W'(d_s6[5]);

		f_a  = (d_s6[0] <= 0) && (d_s6[1] <= 0);
		f_b  = (d_s6[2] >= 0) && (d_s6[3] <= d_s6[2]);
		f_ab = (vc_s6 <= 0) && (d_s6[0] >= 0) && (d_s6[2] <= 0);
		f_c  = (d_s6[5] >= 0) && (d_s6[4] <= d_s6[5]);
		f_ac = (vb_s6 <= 0) && (d_s6[1] >= 0) && (d_s6[5] <= 0);
		f_bc = (va_s6 <= 0) && (d_s6[3] >= d_s6[2]) && (d_s6[4] >= d_s6[5]);

		// Default: closest point is vertex A with a zero offset.
		job.sa        = '0;
		job.sb        = '0;
		job.ea        = '{default: '0};
		job.eb        = '{default: '0};
		job.side.den  = DEN_W'(1);
		job.side.base = pt_s6[1];
		job.side.pt   = pt_s6[0];
		job.side.deg  = 1'b0;

		if (f_a) begin
			// Vertex A region: the defaults already describe it.
			job.side.deg = 1'b0;
		end else if (f_b) begin
			job.side.base = pt_s6[2];
		end else if (f_ab) begin
			if (td_ab > 0) begin
				job.sa       = V_W'(d_s6[0]);
				job.ea       = ab;
				job.side.den = DEN_W'(td_ab);
			end
		end else if (f_c) begin
			job.side.base = pt_s6[3];
		end else if (f_ac) begin
			if (td_ac > 0) begin
				job.sa       = V_W'(d_s6[1]);
				job.ea       = ac;
				job.side.den = DEN_W'(td_ac);
			end
		end else if (f_bc) begin
			job.side.base = pt_s6[2];
			if (td_bc > 0) begin
				job.sa       = V_W'(tn_bc);
				job.ea       = bc;
				job.side.den = DEN_W'(td_bc);
			end
		end else if (den <= 0) begin
			job.side.deg = 1'b1;
		end else begin
			job.sa       = vb_s6;
			job.ea       = ab;
			job.sb       = vc_s6;
			job.eb       = ac;
			job.side.den = DEN_W'(den);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			job_s7 <= job;
		end
	end

endmodule

### design/ptd_numer.sv
module ptd_numer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ptd_pkg::job_t in_job,
	output logic          out_valid,
	input  logic          out_ready,
	output ptd_pkg::div_t out_data
);
	import ptd_pkg::*;

	localparam int NSTG = 4;

	logic vld_s [1:NSTG];
	logic rdy   [1:NSTG];

	logic signed [PART_W-1:0] pa_s1 [3][NCHUNK];
	logic signed [PART_W-1:0] pb_s1 [3][NCHUNK];
	side_t                    side_s1;
	side_t                    side_s2;
	side_t                    side_s3;
	logic signed [NUM_W-1:0]  na_s2 [3];
	logic signed [NUM_W-1:0]  nb_s2 [3];
	logic signed [NUM_W-1:0]  n_s3  [3];
	div_t                     dv_s4;

	logic signed [NUM_W-1:0]  na [3];
	logic signed [NUM_W-1:0]  nb [3];
	logic [DEN_W-1:0]         half;
	div_t                     dv;

	// One chunk of a wide signed word; only the top chunk carries the sign.
	function automatic logic signed [CK_W-1:0] chunk (
		input logic signed [V_W-1:0] w,
		input int                    c
	);
		logic signed [CK_W-1:0] r;
		if (c == NCHUNK - 1) begin
			r = CK_W'($signed(w[V_W-1:(NCHUNK-1)*CHUNK_W]));
		end else begin
			r = $signed({1'b0, w[c*CHUNK_W +: CHUNK_W]});
		end
		return r;
	endfunction

	always_comb begin
		rdy[NSTG] = !vld_s[NSTG] || out_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_s[NSTG];
	assign out_data  = dv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Stage 1: chunk-by-edge partial products for both numerator terms.
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			side_s1 <= in_job.side;
			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < NCHUNK; c++) begin
					pa_s1[i][c] <= chunk(in_job.sa, c) * in_job.ea[i];
					pb_s1[i][c] <= chunk(in_job.sb, c) * in_job.eb[i];
				end
			end
		end
	end

	// Stage 2: weight the partial products by their chunk position.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			na[i] = '0;
			nb[i] = '0;
			for (int c = 0; c < NCHUNK; c++) begin
				na[i] = na[i] + (NUM_W'(pa_s1[i][c]) <<< (c * CHUNK_W));
				nb[i] = nb[i] + (NUM_W'(pb_s1[i][c]) <<< (c * CHUNK_W));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			side_s2 <= side_s1;
			na_s2   <= na;
			nb_s2   <= nb;
		end
	end

	// Stage 3: full signed numerator per axis.
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			side_s3 <= side_s2;
			for (int i = 0; i < 3; i++) begin
				n_s3[i] <= na_s2[i] + nb_s2[i];
			end
		end
	end

	// Stage 4: magnitude plus half the divisor, for round to nearest.
	always_comb begin
		half    = side_s3.den >> 1;
		dv.side = side_s3;
		for (int i = 0; i < 3; i++) begin
			dv.neg[i] = n_s3[i][NUM_W-1];
			dv.quo[i] = '0;
			if (dv.neg[i]) begin
				dv.rem[i] = REM_W'(half) - REM_W'(n_s3[i]);
			end else begin
				dv.rem[i] = REM_W'(n_s3[i]) + REM_W'(half);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			dv_s4 <= dv;
		end
	end

endmodule

### design/ptd_divider.sv
module ptd_divider (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ptd_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ptd_pkg::div_t out_data
);
	import ptd_pkg::*;

	div_t dv_s  [QUOT_W];
	logic vld_s [QUOT_W];
	logic rdy   [QUOT_W];

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[QUOT_W-1];
	assign out_data  = dv_s[QUOT_W-1];

	// One restoring step per stage, most significant quotient bit first.
	for (genvar k = 0; k < QUOT_W; k++) begin : g_step
		localparam int SH = QUOT_W - 1 - k;

		div_t src;
		div_t nxt;
		logic src_v;
		logic nxt_rdy;

		if (k == 0) begin : g_head
			assign src   = in_data;
			assign src_v = in_valid;
		end else begin : g_body
			assign src   = dv_s[k-1];
			assign src_v = vld_s[k-1];
		end

		if (k == QUOT_W - 1) begin : g_tail
			assign nxt_rdy = out_ready;
		end else begin : g_mid
			assign nxt_rdy = rdy[k+1];
		end

		assign rdy[k] = !vld_s[k] || nxt_rdy;

		// Subtract the shifted divisor where it fits, on all three axes.
		always_comb begin
			logic [CMP_W-1:0] trial;
			nxt = src;
			for (int i = 0; i < 3; i++) begin
				trial = CMP_W'(src.rem[i]) - (CMP_W'(src.side.den) << SH);
				if (!trial[CMP_W-1]) begin
					nxt.rem[i]     = trial[REM_W-1:0];
					nxt.quo[i][SH] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				dv_s[k] <= nxt;
			end
		end
	end

endmodule

### design/ptd_dist.sv
module ptd_dist (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ptd_pkg::div_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ptd_pkg::result_t out_data
);
	import ptd_pkg::*;

	localparam int NSTG = 3;

	logic vld_s [1:NSTG];
	logic rdy   [1:NSTG];

	logic signed [DD_W-1:0] dd_s1  [3];
	logic                   deg_s1;
	logic signed [SQ_W-1:0] sq_s2  [3];
	logic                   deg_s2;
	result_t                res_s3;

	logic signed [OFS_W-1:0] ofs [3];
	logic [SQ_W+1:0]         sum;

	always_comb begin
		rdy[NSTG] = !vld_s[NSTG] || out_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_s[NSTG];
	assign out_data  = res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Stage 1: signed offset from the base vertex, then P minus the closest point.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ofs[i] = $signed({1'b0, in_data.quo[i]});
			if (in_data.neg[i]) begin
				ofs[i] = -ofs[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			deg_s1 <= in_data.side.deg;
			for (int i = 0; i < 3; i++) begin
				dd_s1[i] <= DD_W'(in_data.side.pt[i]) - DD_W'(in_data.side.base[i])
					- DD_W'(ofs[i]);
			end
		end
	end

	// Stage 2: per-axis squares.
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			deg_s2 <= deg_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= dd_s1[i] * dd_s1[i];
			end
		end
	end

	// Stage 3: sum of squares; a degenerate triangle reports zero.
	assign sum = (SQ_W+2)'(sq_s2[0]) + (SQ_W+2)'(sq_s2[1]) + (SQ_W+2)'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			res_s3.degenerate  <= deg_s2;
			res_s3.distance_sq <= deg_s2 ? '0 : sum[OUT_W-1:0];
		end
	end

endmodule

### design/point_triangle_distance_squared_core.sv
// Channel   Direction  Payload                          Transfer when
// query     in         P, A, B, C (12 x Q12.12 signed)  query.valid && query.ready
// result    out        distance_sq (Q28.24), degenerate result.valid && result.ready
//
// One query enters per cycle when nothing stalls; each result passes in order through
// 7 geometry stages, 4 numerator stages, 27 divider steps (one quotient bit each)
// and 3 distance stages. The divider is the longest of the four parts.
// Reset clears only the stage valid bits. A stalled result holds in the output
// register while earlier stages keep filling any empty slots.
module point_triangle_distance_squared_core (
	input  logic         clk,
	input  logic         arst_n,
	ptd_query_if.sink    query,
	ptd_result_if.source result
);
	import ptd_pkg::*;

	logic  geo_valid;
	logic  geo_ready;
	job_t  geo_job;
	logic  num_valid;
	logic  num_ready;
	div_t  num_data;
	logic  div_valid;
	logic  div_ready;
	div_t  div_data;

	// Dot products, cross terms and region choice.
	ptd_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query.valid),
		.in_ready  (query.ready),
		.in_data   (query.data),
		.out_valid (geo_valid),
		.out_ready (geo_ready),
		.out_job   (geo_job)
	);

	// Division numerators and rounding bias.
	ptd_numer u_numer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (geo_valid),
		.in_ready  (geo_ready),
		.in_job    (geo_job),
		.out_valid (num_valid),
		.out_ready (num_ready),
		.out_data  (num_data)
	);

	// Pipelined restoring divider, three axes side by side.
	ptd_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (num_valid),
		.in_ready  (num_ready),
		.in_data   (num_data),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	// Closest point and squared distance.
	ptd_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_data   (div_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.data)
	);

endmodule

### bench/point_triangle_distance_squared_core_test.sv
`timescale 1ns / 1ps

module point_triangle_distance_squared_core_test;
	import ptd_pkg::*;

	typedef logic signed [159:0] wide_t;
	typedef longint vec3_t [3];

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;

	ptd_query_if  query_ch ();
	ptd_result_if result_ch ();

	point_triangle_distance_squared_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_ch),
		.result (result_ch)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	result_t expected_results [$];
	int      mismatches;
	int      idle_cycles;
	int      hold_left;
	bit      hold_request;
	bit      steady_flow;

	// Divide and round to nearest, ties away from zero; the divisor is positive.
	function automatic wide_t round_div(wide_t num, wide_t den);
		wide_t mag;
		wide_t quo;
		mag = (num < 0) ? -num : num;
		quo = (mag + (den >>> 1)) / den;
		return (num < 0) ? -quo : quo;
	endfunction

	// Project onto an edge; a zero-length edge keeps its start vertex.
	function automatic void edge_point(output vec3_t pt, input vec3_t base,
			input vec3_t dir, input longint tn, input longint td);
		for (int i = 0; i < 3; i++) begin
			if (td <= 0)
				pt[i] = base[i];
			else
				pt[i] = base[i] + longint'(round_div(wide_t'(tn) * wide_t'(dir[i]),
					wide_t'(td)));
		end
	endfunction

	function automatic longint dot(vec3_t u, vec3_t v);
		return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
	endfunction

	// Closest point by region classification, then the exact squared distance.
	function automatic result_t predict_distance(query_t q);
		vec3_t p, a, b, c, r, ab, ac, bc, ap, bp, cp;
		longint d1, d2, d3, d4, d5, d6, dd;
		wide_t va, vb, vc, den;
		logic [63:0] sum;
		logic deg;
		result_t res;
		p = '{q.point_x, q.point_y, q.point_z};
		a = '{q.vert_a_x, q.vert_a_y, q.vert_a_z};
		b = '{q.vert_b_x, q.vert_b_y, q.vert_b_z};
		c = '{q.vert_c_x, q.vert_c_y, q.vert_c_z};
		for (int i = 0; i < 3; i++) begin
			ab[i] = b[i] - a[i];
			ac[i] = c[i] - a[i];
			bc[i] = c[i] - b[i];
			ap[i] = p[i] - a[i];
			bp[i] = p[i] - b[i];
			cp[i] = p[i] - c[i];
		end
		d1 = dot(ab, ap);
		d2 = dot(ac, ap);
		d3 = dot(ab, bp);
		d4 = dot(ac, bp);
		d5 = dot(ab, cp);
		d6 = dot(ac, cp);
		vc = wide_t'(d1) * wide_t'(d4) - wide_t'(d3) * wide_t'(d2);
		vb = wide_t'(d5) * wide_t'(d2) - wide_t'(d1) * wide_t'(d6);
		va = wide_t'(d3) * wide_t'(d6) - wide_t'(d5) * wide_t'(d4);
		den = va + vb + vc;
		deg = 1'b0;
		r = p;
		if (d1 <= 0 && d2 <= 0)
			r = a;
		else if (d3 >= 0 && d4 <= d3)
			r = b;
		else if (vc <= 0 && d1 >= 0 && d3 <= 0)
			edge_point(r, a, ab, d1, d1 - d3);
		else if (d6 >= 0 && d5 <= d6)
			r = c;
		else if (vb <= 0 && d2 >= 0 && d6 <= 0)
			edge_point(r, a, ac, d2, d2 - d6);
		else if (va <= 0 && d4 >= d3 && d5 >= d6)
			edge_point(r, b, bc, d4 - d3, (d4 - d3) + (d5 - d6));
		else if (den <= 0)
			deg = 1'b1;
		else begin
			for (int i = 0; i < 3; i++)
				r[i] = a[i] + longint'(round_div(vb * wide_t'(ab[i]) + vc * wide_t'(ac[i]),
					den));
		end
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			dd = p[i] - r[i];
			sum = sum + 64'(dd * dd);
		end
		res.distance_sq = deg ? '0 : sum[OUT_W-1:0];
		res.degenerate = deg;
		return res;
	endfunction

	function automatic coord_t rand_coord(bit narrow);
		if (narrow)
			return coord_t'($signed($urandom_range(16384)) - 8192);
		return coord_t'($urandom);
	endfunction

	// Random query: wide, narrow, collinear or with repeated vertices.
	function automatic query_t rand_query();
		query_t q;
		int kind;
		bit narrow;
		int k;
		kind = $urandom_range(9);
		narrow = (kind >= 3);
		q.point_x  = rand_coord(narrow);
		q.point_y  = rand_coord(narrow);
		q.point_z  = rand_coord(narrow);
		q.vert_a_x = rand_coord(narrow);
		q.vert_a_y = rand_coord(narrow);
		q.vert_a_z = rand_coord(narrow);
		q.vert_b_x = rand_coord(narrow);
		q.vert_b_y = rand_coord(narrow);
		q.vert_b_z = rand_coord(narrow);
		q.vert_c_x = rand_coord(narrow);
		q.vert_c_y = rand_coord(narrow);
		q.vert_c_z = rand_coord(narrow);
		if (kind == 7) begin
			// Collinear vertices: C is a multiple of B - A from A.
			k = $signed($urandom_range(6)) - 3;
			q.vert_b_x = q.vert_a_x + coord_t'($signed($urandom_range(200)) - 100);
			q.vert_b_y = q.vert_a_y + coord_t'($signed($urandom_range(200)) - 100);
			q.vert_b_z = q.vert_a_z + coord_t'($signed($urandom_range(200)) - 100);
			q.vert_c_x = q.vert_a_x + coord_t'(k * (q.vert_b_x - q.vert_a_x));
			q.vert_c_y = q.vert_a_y + coord_t'(k * (q.vert_b_y - q.vert_a_y));
			q.vert_c_z = q.vert_a_z + coord_t'(k * (q.vert_b_z - q.vert_a_z));
		end else if (kind == 8) begin
			case ($urandom_range(2))
				0: {q.vert_b_x, q.vert_b_y, q.vert_b_z} = {q.vert_a_x, q.vert_a_y, q.vert_a_z};
				1: {q.vert_c_x, q.vert_c_y, q.vert_c_z} = {q.vert_a_x, q.vert_a_y, q.vert_a_z};
				default: {q.vert_c_x, q.vert_c_y, q.vert_c_z} =
					{q.vert_b_x, q.vert_b_y, q.vert_b_z};
			endcase
		end
		return q;
	endfunction

	function automatic int rand_gap();
		int pick;
		if (steady_flow)
			return 0;
		pick = $urandom_range(99);
		if (pick < 60)
			return 0;
		if (pick < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Offer one query and wait for its transfer, then record the expected result.
	task automatic send_query(query_t q);
		int gap;
		query_ch.valid <= 1'b1;
		query_ch.data <= q;
		do
			@(posedge clk);
		while (!query_ch.ready);
		expected_results.insert(expected_results.size(), predict_distance(q));
		gap = rand_gap();
		if (gap > 0) begin
			query_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic query_t make_query(int px, int py, int pz,
			int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz);
		return '{coord_t'(px), coord_t'(py), coord_t'(pz),
			coord_t'(ax), coord_t'(ay), coord_t'(az),
			coord_t'(bx), coord_t'(by), coord_t'(bz),
			coord_t'(cx), coord_t'(cy), coord_t'(cz)};
	endfunction

	// Extreme coordinates: queries built from the limits and from zero.
	task automatic test_extremes();
		int mx, mn;
		mx = 8388607;
		mn = -8388608;
		send_query(make_query(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
		send_query(make_query(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
		send_query(make_query(mx, mx, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn));
		send_query(make_query(mn, mn, mn, mx, mx, mx, mn, mx, mx, mx, mn, mx));
		send_query(make_query(mx, mn, mx, mn, mx, mn, mx, mx, mn, mn, mn, mx));
		send_query(make_query(0, 0, mx, mn, mn, 0, mx, mn, 0, 0, mx, 0));
		send_query(make_query(0, 0, mn, mn, mn, mn, mx, mn, mx, mn, mx, mx));
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
	endtask

	// One query in each region of the triangle A(0,0,0) B(4,0,0) C(0,4,0), plus one on a small triangle.
	task automatic test_regions();
		int u;
		u = 4096;
		send_query(make_query(-u, -u, u, 0, 0, 0, 4*u, 0, 0, 0, 4*u, 0));
		send_query(make_query(5*u, -u, u, 0, 0, 0, 4*u, 0, 0, 0, 4*u, 0));
		send_query(make_query(-u, 5*u, -u, 0, 0, 0, 4*u, 0, 0, 0, 4*u, 0));
		send_query(make_query(2*u, -u, u, 0, 0, 0, 4*u, 0, 0, 0, 4*u, 0));
		send_query(make_query(-u, 2*u, 3, 0, 0, 0, 4*u, 0, 0, 0, 4*u, 0));
		send_query(make_query(3*u, 3*u, 7, 0, 0, 0, 4*u, 0, 0, 0, 4*u, 0));
		send_query(make_query(u, u, -2*u, 0, 0, 0, 4*u, 0, 0, 0, 4*u, 0));
		send_query(make_query(1, 2, 5, 0, 0, 0, 3, 0, 0, 0, 3, 0));
	endtask

	// Zero-length edges and collinear triangles with no positive denominator.
	task automatic test_degenerate();
		int u;
		u = 4096;
		send_query(make_query(u, u, u, 0, 0, 0, 0, 0, 0, 0, 4*u, 0));
		send_query(make_query(u, -u, 0, 0, 0, 0, 4*u, 0, 0, 0, 0, 0));
		send_query(make_query(2*u, 2*u, u, 0, 0, 0, 4*u, 0, 0, 4*u, 0, 0));
		send_query(make_query(u, u, 0, 0, 0, 0, 4*u, 0, 0, 2*u, 0, 0));
		send_query(make_query(2*u, 3*u, u, 0, 0, 0, 4*u, 0, 0, -4*u, 0, 0));
		send_query(make_query(5, 7, 0, 0, 0, 0, 8, 8, 8, 16, 16, 16));
		send_query(make_query(u, u, u, u, u, u, u, u, u, u, u, u));
	endtask

	task automatic test_random(int count);
		repeat (count) send_query(rand_query());
	endtask

	// Long receiver hold while queries stream in back to back.
	task automatic test_backpressure();
		steady_flow = 1'b1;
		hold_request = 1'b1;
		repeat (120) send_query(rand_query());
		steady_flow = 1'b0;
	endtask

	// Result side: check each transfer and choose the next ready.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: distance_sq=%h degenerate=%b",
						result_ch.data.distance_sq, result_ch.data.degenerate);
			end else begin
				want = expected_results.pop_front();
				if (result_ch.data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected distance_sq=%h degenerate=%b, got %h %b",
							want.distance_sq, want.degenerate,
							result_ch.data.distance_sq, result_ch.data.degenerate);
				end
			end
		end
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (steady_flow)
			result_ch.ready <= 1'b1;
		else if ($urandom_range(99) < 2) begin
			// An occasional longer pause on the receiving side.
			hold_left = $urandom_range(40, 10);
			result_ch.ready <= 1'b0;
		end else
			result_ch.ready <= ($urandom_range(99) < 75);
	end

	// Watchdog on cycles with no transfer at all.
	always @(posedge clk) begin
		if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		query_ch.valid = 1'b0;
		query_ch.data = '0;
		result_ch.ready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		hold_left = 0;
		hold_request = 1'b0;
		steady_flow = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_regions();
		test_degenerate();
		test_random(500);
		test_backpressure();
		test_random(500);

		query_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
design/ptd_pkg.sv
design/ptd_query_if.sv
design/ptd_result_if.sv
design/ptd_geom.sv
design/ptd_numer.sv
design/ptd_divider.sv
design/ptd_dist.sv
design/point_triangle_distance_squared_core.sv
bench/point_triangle_distance_squared_core_test.sv
